[design/assert_macros.svh]
// assertion macros shared by the json token scanner modules
// no dependencies; define SYNTH to drop the checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define JTS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define JTS_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define JTS_ASSERT(lbl, clk, rstn, prop)
`define JTS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[design/jts_pkg.sv]
// shared types, codes and keyword tables of the json token scanner
// no dependencies
`timescale 1ns / 1ps

package jts_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [1:0]  error_code;
		logic [23:0] start_pos;
		logic [23:0] lexeme_length;
		logic [15:0] line;
		logic        run_end;
	} out_item_t;

	// token kinds
	localparam logic [3:0] KIND_LBRACE   = 4'd0;
	localparam logic [3:0] KIND_RBRACE   = 4'd1;
	localparam logic [3:0] KIND_LBRACKET = 4'd2;
	localparam logic [3:0] KIND_RBRACKET = 4'd3;
	localparam logic [3:0] KIND_COMMA    = 4'd4;
	localparam logic [3:0] KIND_COLON    = 4'd5;
	localparam logic [3:0] KIND_STRING   = 4'd6;
	localparam logic [3:0] KIND_NUMBER   = 4'd7;
	localparam logic [3:0] KIND_EOF      = 4'd11;
	localparam logic [3:0] KIND_ERROR    = 4'd12;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_UNTERM   = 2'd1;
	localparam logic [1:0] ERR_BAD_CHAR = 2'd2;
	localparam logic [1:0] ERR_BAD_WORD = 2'd3;

	// keyword ids
	localparam logic [1:0] KW_NONE  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_TRUE  = 2'd2;
	localparam logic [1:0] KW_NULL  = 2'd3;

	// characters
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_UNDER    = 8'h5F;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;

	// tokens one byte can give, and the queue between front and back
	localparam int TOK_SLOTS   = 3;
	localparam int SLOT_BITS   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = 3;

	typedef struct packed {
		logic [SLOT_BITS-1:0]            count;
		out_item_t [TOK_SLOTS-1:0]       tok;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic [2:0] kw_len(input logic [1:0] id);
		case (id)
			KW_FALSE: return 3'd5;
			KW_TRUE:  return 3'd4;
			KW_NULL:  return 3'd4;
			default:  return 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] idx);
		case ({id, idx})
			{KW_FALSE, 3'd0}: return "f";
			{KW_FALSE, 3'd1}: return "a";
			{KW_FALSE, 3'd2}: return "l";
			{KW_FALSE, 3'd3}: return "s";
			{KW_FALSE, 3'd4}: return "e";
			{KW_TRUE, 3'd0}:  return "t";
			{KW_TRUE, 3'd1}:  return "r";
			{KW_TRUE, 3'd2}:  return "u";
			{KW_TRUE, 3'd3}:  return "e";
			{KW_NULL, 3'd0}:  return "n";
			{KW_NULL, 3'd1}:  return "u";
			{KW_NULL, 3'd2}:  return "l";
			{KW_NULL, 3'd3}:  return "l";
			default:          return 8'h00;
		endcase
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {["a":"z"], ["A":"Z"]}) || (c == CH_UNDER);
	endfunction

endpackage

[design/jts_front.sv]
// front end: takes one byte a cycle while the queue is not full, runs the lexer state and forms a token bundle
// depends on jts_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jts_front import jts_pkg::*; #(
	parameter int POS_BITS  = 24,
	parameter int LINE_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	input  in_item_t byte_item,
	input  logic     full,
	output logic     push,
	output bundle_t  bundle
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_STR  = 6'b000010,
		ST_INT  = 6'b000100,
		ST_DOT  = 6'b001000,
		ST_FRAC = 6'b010000,
		ST_WORD = 6'b100000
	} lex_state_t;

	localparam logic [POS_BITS-1:0]  POS_MAX  = '1;
	localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
	localparam logic [POS_BITS-1:0]  POS_ONE  = POS_BITS'(1);

	function automatic logic [POS_BITS-1:0] inc_pos(input logic [POS_BITS-1:0] v);
		return (v == POS_MAX) ? v : v + POS_ONE;
	endfunction

	function automatic logic [LINE_BITS-1:0] inc_line(input logic [LINE_BITS-1:0] v);
		return (v == LINE_MAX) ? v : v + LINE_BITS'(1);
	endfunction

	function automatic logic [POS_BITS-1:0] sub0(input logic [POS_BITS-1:0] a,
			input logic [POS_BITS-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	function automatic out_item_t mk(input logic [3:0] kind, input logic [1:0] code,
			input logic [POS_BITS-1:0] start, input logic [POS_BITS-1:0] len,
			input logic [LINE_BITS-1:0] ln);
		out_item_t t;
		logic [POS_BITS+23:0]  s_ext;
		logic [POS_BITS+23:0]  l_ext;
		logic [LINE_BITS+15:0] n_ext;
		s_ext = {24'b0, start};
		l_ext = {24'b0, len};
		n_ext = {16'b0, ln};
		t.kind          = kind;
		t.error_code    = code;
		t.start_pos     = s_ext[23:0];
		t.lexeme_length = l_ext[23:0];
		t.line          = n_ext[15:0];
		t.run_end       = 1'b0;
		return t;
	endfunction

	lex_state_t           st_q, nst;
	logic [LINE_BITS-1:0] line_q, nline;
	logic [POS_BITS-1:0]  pos_q, tstart_q, ntstart;
	logic [1:0]           kid_q, nkid;
	logic [2:0]           kcnt_q, nkcnt;
	logic                 halted_q, nhalt;

	logic [7:0]           c;
	logic                 last;
	logic [POS_BITS-1:0]  p, pn, pm1, tsi;
	logic                 redo;
	logic [SLOT_BITS-1:0] n;
	out_item_t            tok [TOK_SLOTS];
	logic                 accept;

	assign c      = byte_item.ch;
	assign last   = byte_item.last;
	assign p      = pos_q;
	assign pn     = inc_pos(pos_q);
	assign pm1    = sub0(pos_q, POS_ONE);
	assign tsi    = inc_pos(tstart_q);
	assign accept = byte_valid && !full;

	always_comb begin
		n       = '0;
		redo    = 1'b1;
		nst     = st_q;
		nline   = line_q;
		ntstart = tstart_q;
		nkid    = kid_q;
		nkcnt   = kcnt_q;
		nhalt   = halted_q;
		for (int i = 0; i < TOK_SLOTS; i++) begin
			tok[i] = '0;
		end

		// finish or extend the pending token
		case (st_q)
			ST_STR: begin
				redo = 1'b0;
				if (c == CH_QUOTE) begin
					tok[n] = mk(KIND_STRING, ERR_NONE, tsi, sub0(p, tsi), nline);
					n = n + 1'b1;
					nst = ST_IDLE;
				end else if (c == CH_NL) begin
					nline = inc_line(nline);
				end
			end
			ST_INT, ST_FRAC: begin
				if (is_digit(c)) begin
					redo = 1'b0;
				end else if (c == CH_DOT && st_q == ST_INT) begin
					redo = 1'b0;
					nst = ST_DOT;
				end else begin
					tok[n] = mk(KIND_NUMBER, ERR_NONE, tstart_q, sub0(p, tstart_q), nline);
					n = n + 1'b1;
					nst = ST_IDLE;
				end
			end
			ST_DOT: begin
				redo = 1'b0;
				if (is_digit(c)) begin
					nst = ST_FRAC;
				end else begin
					// number closes before the dot, the dot itself is bad
					tok[n] = mk(KIND_NUMBER, ERR_NONE, tstart_q, sub0(pm1, tstart_q), nline);
					n = n + 1'b1;
					tok[n] = mk(KIND_ERROR, ERR_BAD_CHAR, pm1, POS_ONE, nline);
					n = n + 1'b1;
					nhalt = 1'b1;
					nst = ST_IDLE;
				end
			end
			ST_WORD: begin
				if (is_digit(c) || is_alpha(c)) begin
					redo = 1'b0;
					if (kid_q != KW_NONE && kcnt_q < kw_len(kid_q)
							&& kw_char(kid_q, kcnt_q) == c) begin
						nkcnt = kcnt_q + 3'd1;
					end else begin
						nkid  = KW_NONE;
						nkcnt = 3'd0;
					end
				end else begin
					nst = ST_IDLE;
					if (kid_q != KW_NONE && kcnt_q == kw_len(kid_q)) begin
						tok[n] = mk(KIND_NUMBER + 4'(kid_q), ERR_NONE, tstart_q,
							sub0(p, tstart_q), nline);
						n = n + 1'b1;
					end else begin
						tok[n] = mk(KIND_ERROR, ERR_BAD_WORD, tstart_q,
							sub0(p, tstart_q), nline);
						n = n + 1'b1;
						nhalt = 1'b1;
					end
				end
			end
			default: begin
				nst = ST_IDLE;
			end
		endcase

		// start of a new token, or punctuation
		if (redo && !nhalt) begin
			case (c)
				CH_LBRACE: begin
					tok[n] = mk(KIND_LBRACE, ERR_NONE, p, POS_ONE, nline);
					n = n + 1'b1;
				end
				CH_RBRACE: begin
					tok[n] = mk(KIND_RBRACE, ERR_NONE, p, POS_ONE, nline);
					n = n + 1'b1;
				end
				CH_LBRACKET: begin
					tok[n] = mk(KIND_LBRACKET, ERR_NONE, p, POS_ONE, nline);
					n = n + 1'b1;
				end
				CH_RBRACKET: begin
					tok[n] = mk(KIND_RBRACKET, ERR_NONE, p, POS_ONE, nline);
					n = n + 1'b1;
				end
				CH_COMMA: begin
					tok[n] = mk(KIND_COMMA, ERR_NONE, p, POS_ONE, nline);
					n = n + 1'b1;
				end
				CH_COLON: begin
					tok[n] = mk(KIND_COLON, ERR_NONE, p, POS_ONE, nline);
					n = n + 1'b1;
				end
				CH_SPACE, CH_CR, CH_TAB: begin
				end
				CH_NL: begin
					nline = inc_line(nline);
				end
				CH_QUOTE: begin
					ntstart = p;
					nst = ST_STR;
				end
				default: begin
					if (is_digit(c)) begin
						ntstart = p;
						nst = ST_INT;
					end else if (is_alpha(c)) begin
						ntstart = p;
						nst = ST_WORD;
						nkcnt = 3'd1;
						if (c == "f") begin
							nkid = KW_FALSE;
						end else if (c == "t") begin
							nkid = KW_TRUE;
						end else if (c == "n") begin
							nkid = KW_NULL;
						end else begin
							nkid  = KW_NONE;
							nkcnt = 3'd0;
						end
					end else begin
						tok[n] = mk(KIND_ERROR, ERR_BAD_CHAR, p, POS_ONE, nline);
						n = n + 1'b1;
						nhalt = 1'b1;
						nst = ST_IDLE;
					end
				end
			endcase
		end

		// end of document: close what is open, then eof unless an error token was given
		if (last && !nhalt) begin
			case (nst)
				ST_STR: begin
					tok[n] = mk(KIND_ERROR, ERR_UNTERM, inc_pos(ntstart),
						sub0(pn, inc_pos(ntstart)), nline);
					n = n + 1'b1;
					nhalt = 1'b1;
				end
				ST_INT, ST_FRAC: begin
					tok[n] = mk(KIND_NUMBER, ERR_NONE, ntstart, sub0(pn, ntstart), nline);
					n = n + 1'b1;
				end
				ST_DOT: begin
					tok[n] = mk(KIND_NUMBER, ERR_NONE, ntstart, sub0(p, ntstart), nline);
					n = n + 1'b1;
					tok[n] = mk(KIND_ERROR, ERR_BAD_CHAR, p, POS_ONE, nline);
					n = n + 1'b1;
					nhalt = 1'b1;
				end
				ST_WORD: begin
					if (nkid != KW_NONE && nkcnt == kw_len(nkid)) begin
						tok[n] = mk(KIND_NUMBER + 4'(nkid), ERR_NONE, ntstart,
							sub0(pn, ntstart), nline);
						n = n + 1'b1;
					end else begin
						tok[n] = mk(KIND_ERROR, ERR_BAD_WORD, ntstart,
							sub0(pn, ntstart), nline);
						n = n + 1'b1;
						nhalt = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (!nhalt) begin
				tok[n] = mk(KIND_EOF, ERR_NONE, pn, '0, nline);
				n = n + 1'b1;
			end
			nhalt = 1'b1;
			nst = ST_IDLE;
		end
	end

	always_comb begin
		bundle.count = n;
		for (int i = 0; i < TOK_SLOTS; i++) begin
			bundle.tok[i] = tok[i];
		end
	end

	assign push = accept && !halted_q && (n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			line_q   <= LINE_BITS'(1);
			pos_q    <= '0;
			tstart_q <= '0;
			kid_q    <= KW_NONE;
			kcnt_q   <= 3'd0;
			halted_q <= 1'b0;
		end else if (accept && !halted_q) begin
			st_q     <= nst;
			line_q   <= nline;
			pos_q    <= pn;
			tstart_q <= ntstart;
			kid_q    <= nkid;
			kcnt_q   <= nkcnt;
			halted_q <= nhalt;
		end
	end

	`JTS_ASSERT(a_halt_idle, clk, arst_n, halted_q |-> (st_q == ST_IDLE))
	`JTS_ASSERT(a_halt_sticky, clk, arst_n, halted_q |=> halted_q)

endmodule

[design/jts_queue.sv]
// small queue of token bundles between front and back end
// depends on jts_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jts_queue import jts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bundle_t     wr_data,
	input  logic        pop,
	output bundle_t     head,
	output queue_stat_t stat
);

	bundle_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] v);
		return (v == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : v + 1'b1;
	endfunction

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`JTS_NEVER(a_no_overflow, clk, arst_n, stat.full && push)
	`JTS_NEVER(a_no_underflow, clk, arst_n, stat.empty && pop)

endmodule

[design/jts_back.sv]
// back end: register giving each bundle's tokens one per cycle unless stalled
// depends on jts_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jts_back import jts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bundle_t     head,
	input  queue_stat_t stat,
	output logic        pop,
	output logic        tok_valid,
	input  logic        tok_stall,
	output out_item_t   tok_item
);

	bundle_t              cur_q;
	logic [SLOT_BITS-1:0] idx_q;
	logic                 valid_q;
	logic                 last_tok;
	logic                 advance;
	logic                 load;

	assign last_tok = (idx_q == SLOT_BITS'(cur_q.count - 1'b1));
	assign advance  = valid_q && !tok_stall;
	assign load     = !stat.empty && (!valid_q || (advance && last_tok));
	assign pop      = load;

	always_comb begin
		tok_item         = cur_q.tok[idx_q];
		tok_item.run_end = last_tok;
	end
	assign tok_valid = valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (advance) begin
			if (last_tok) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	`JTS_ASSERT(a_idx_in_bundle, clk, arst_n, valid_q |-> (idx_q < cur_q.count))
	`JTS_ASSERT(a_mid_bundle_stays, clk, arst_n, (valid_q && !tok_stall && !last_tok) |=> valid_q)

endmodule

[design/json_token_scanner_unit.sv]
// top level of the json token scanner: front end, bundle queue, back end
// depends on jts_pkg, jts_front, jts_queue and jts_back
`timescale 1ns / 1ps
// an accepted byte's tokens pass the bundle queue, then the back end output register
// throughput: one byte per cycle unless stalled; the back end sends its tokens in turn
// the four-entry bundle queue soaks up bursts, the byte side stalls only when it is full
// reset: asynchronous, active low; lexer idle, line 1, offset 0, queue and output empty

module json_token_scanner_unit import jts_pkg::*; #(
	parameter int POS_BITS  = 24,
	parameter int LINE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	// byte side
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_item,
	// token side
	output logic      tok_valid,
	input  logic      tok_stall,
	output out_item_t tok_item
);

	// bundle from the front end, up to three tokens caused by one byte
	bundle_t     fr_bundle;
	logic        fr_push;
	// queue head and status seen by the back end
	bundle_t     q_head;
	queue_stat_t q_stat;
	logic        bk_pop;

	// byte side stalls only while the queue has no room for a bundle
	assign byte_stall = q_stat.full;

	// classifies each item and keeps offsets, line count and keyword match
	jts_front #(
		.POS_BITS  (POS_BITS),
		.LINE_BITS (LINE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_item  (byte_item),
		.full       (q_stat.full),
		.push       (fr_push),
		.bundle     (fr_bundle)
	);

	// decouples the two sides so either can stall alone
	jts_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fr_push),
		.wr_data (fr_bundle),
		.pop     (bk_pop),
		.head    (q_head),
		.stat    (q_stat)
	);

	// output register, walks through each bundle and marks its last token
	jts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.stat      (q_stat),
		.pop       (bk_pop),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

endmodule
